@@ rtl/bgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge monitor package
// Word types, opcodes, property codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package bgm_pkg;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [2:0] PROP_STATUS   = 3'd0;
  localparam logic [2:0] PROP_VOLTAGE  = 3'd1;
  localparam logic [2:0] PROP_ONLINE   = 3'd2;
  localparam logic [2:0] PROP_CAPACITY = 3'd3;

  localparam logic [1:0] SRC_AC  = 2'd1;
  localparam logic [1:0] SRC_BAT = 2'd2;

  localparam logic [14:0] VOLT_MAX  = 15'd30000;
  localparam logic [14:0] VOLT_RST  = 15'd8400;
  localparam logic [6:0]  LEVEL_RST = 7'd100;
  localparam logic [8:0]  SCALE_RST = 9'd252;

  typedef struct packed {
    logic        opcode;
    logic [15:0] adc_word;
    logic [2:0]  property_req;
    logic        is_battery_supply;
    logic        power_good_pin;
    logic        charge_done_pin;
    logic        charging_pin;
  } in_word_t;

  typedef struct packed {
    logic [14:0] value;
    logic        invalid_property;
  } out_word_t;

  typedef struct packed {
    logic        vld;
    in_word_t    word;
    logic [14:0] mv;
  } pend_t;

endpackage

@@ rtl/bgm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge front pipeline
// Input register and ADC-to-millivolt scaling stages; every word rides along.
// ----------------------------------------------------------------------------
module bgm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [8:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  bgm_pkg::in_word_t in_word,
  input  logic             take,
  output bgm_pkg::pend_t   pend
);
  import bgm_pkg::*;

  localparam int NSTG = 5;
  localparam logic [12:0] ADC_GAIN = 13'd6000;
  localparam logic [19:0] RECIP25  = 20'd671088;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  in_word_t        word_q [NSTG];
  logic [8:0]      scale;

  logic [22:0] prod_b;
  logic [12:0] mv1_c;
  logic [21:0] prod_d;
  logic [19:0] y_e;
  logic [15:0] qe;

  logic [22:0] prod_b_next;
  logic [22:0] sum_c;
  logic [12:0] q0_c;
  logic [22:0] rem_c;
  logic [12:0] mv1_next;
  logic [21:0] prod_d_next;
  logic [19:0] y_next;
  logic [39:0] recip_prod;
  logic [15:0] qe_next;
  logic [20:0] m25;
  logic [20:0] rem_e;
  logic [15:0] q_e;
  logic [14:0] mv_out;

  always_comb begin
    rdy[NSTG] = take;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    prod_b_next = {13'd0, word_q[0].adc_word[15:6]} * {10'd0, ADC_GAIN};
    sum_c       = prod_b + {10'd0, prod_b[22:10]} + {20'd0, prod_b[22:20]};
    q0_c        = sum_c[22:10];
    rem_c       = prod_b - ({q0_c, 10'd0} - {10'd0, q0_c});
    mv1_next    = q0_c + {12'd0, (rem_c >= 23'd1023)};
    prod_d_next = {9'd0, mv1_c} * {13'd0, scale};
    y_next      = prod_d[21:2];
    recip_prod  = {20'd0, y_next} * {20'd0, RECIP25};
    qe_next     = recip_prod[39:24];
    m25         = {1'b0, qe, 4'd0} + {2'b0, qe, 3'd0} + {5'd0, qe};
    rem_e       = {1'b0, y_e} - m25;
    q_e         = qe + {15'd0, (rem_e >= 21'd25)};
    mv_out      = (q_e > {1'b0, VOLT_MAX}) ? VOLT_MAX : q_e[14:0];
  end

  assign pend = '{vld: vld[NSTG-1], word: word_q[NSTG-1], mv: mv_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      scale <= SCALE_RST;
    end else begin
      if (cfg_wr_en) begin
        scale <= cfg_wr_data;
      end
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      word_q[0] <= in_word;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        word_q[i] <= word_q[i-1];
      end
    end
    if (rdy[1]) begin
      prod_b <= prod_b_next;
    end
    if (rdy[2]) begin
      mv1_c <= mv1_next;
    end
    if (rdy[3]) begin
      prod_d <= prod_d_next;
    end
    if (rdy[4]) begin
      y_e <= y_next;
      qe  <= qe_next;
    end
  end

`ifndef SYNTH
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0])
    else $error("input stalled with empty input stage");
  a_mv_in_range: assert property (@(posedge clk) disable iff (rst)
    pend.vld |-> (mv_out <= VOLT_MAX))
    else $error("scaled voltage above limit");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (rem_c < 23'd2046))
    else $error("divide-by-1023 estimate out of bound");
`endif

endmodule

@@ rtl/bgm_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge query stage
// Gauge state, property decode, capacity lookup and the result register.
// ----------------------------------------------------------------------------
module bgm_query (
  input  logic              clk,
  input  logic              rst,
  input  bgm_pkg::pend_t    pend,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output bgm_pkg::out_word_t out_word
);
  import bgm_pkg::*;

  localparam logic [14:0] AC_LIMIT [10] = '{
    15'd8400, 15'd8160, 15'd8120, 15'd8060, 15'd7990,
    15'd7930, 15'd7880, 15'd7780, 15'd7710, 15'd7550};
  localparam logic [6:0] AC_LEVEL [11] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5};
  localparam logic [14:0] BAT_LIMIT [11] = '{
    15'd8060, 15'd7930, 15'd7800, 15'd7690, 15'd7580, 15'd7470,
    15'd7440, 15'd7400, 15'd7250, 15'd7200, 15'd7090};
  localparam logic [6:0] BAT_LEVEL [12] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0};

  function automatic logic [6:0] level_of(input logic [14:0] mv, input logic ac);
    logic [6:0] lvl;
    if (ac) begin
      lvl = AC_LEVEL[10];
      for (int i = 9; i >= 0; i--) begin
        if (mv > AC_LIMIT[i]) lvl = AC_LEVEL[i];
      end
    end else begin
      lvl = BAT_LEVEL[11];
      for (int i = 10; i >= 0; i--) begin
        if (mv > BAT_LIMIT[i]) lvl = BAT_LEVEL[i];
      end
    end
    return lvl;
  endfunction

  logic [14:0] battery_millivolts;
  logic [6:0]  held_level;
  logic [1:0]  last_source;

  logic [14:0] battery_millivolts_next;
  logic [6:0]  held_level_next;
  logic [1:0]  last_source_next;
  out_word_t   out_word_next;
  logic        commit;
  logic        ac;
  logic [1:0]  source;
  logic [6:0]  level;

  assign take   = !out_valid || !out_stall;
  assign commit = pend.vld && take;

  always_comb begin
    ac     = !pend.word.power_good_pin;
    source = pend.word.power_good_pin ? SRC_BAT : SRC_AC;
    level  = level_of(battery_millivolts, ac);

    battery_millivolts_next = battery_millivolts;
    held_level_next         = held_level;
    last_source_next        = last_source;
    out_word_next           = '{value: 15'd0, invalid_property: 1'b0};

    if (commit && pend.word.opcode == OP_SAMPLE) begin
      battery_millivolts_next = pend.mv;
    end else if (commit) begin
      case (pend.word.property_req)
        PROP_STATUS: begin
          if (!ac) out_word_next.value = 15'd3;
          else if (pend.word.charging_pin) out_word_next.value = 15'd0;
          else if (pend.word.charge_done_pin) out_word_next.value = 15'd1;
          else out_word_next.value = 15'd2;
        end
        PROP_VOLTAGE: begin
          out_word_next.value = battery_millivolts;
        end
        PROP_ONLINE: begin
          out_word_next.value = {14'd0, ac};
        end
        PROP_CAPACITY: begin
          if (!pend.word.is_battery_supply) begin
            out_word_next.value = 15'd100;
          end else if ((last_source & source) != 2'd0) begin
            held_level_next     = level;
            out_word_next.value = {8'd0, level};
          end else begin
            out_word_next.value = {8'd0, held_level};
            last_source_next    = source;
          end
        end
        default: begin
          out_word_next.invalid_property = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      battery_millivolts <= VOLT_RST;
      held_level         <= LEVEL_RST;
      last_source        <= SRC_BAT;
    end else begin
      if (take) begin
        out_valid <= pend.vld && (pend.word.opcode == OP_QUERY);
      end
      battery_millivolts <= battery_millivolts_next;
      held_level         <= held_level_next;
      last_source        <= last_source_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= out_word_next;
    end
  end

`ifndef SYNTH
  a_volt_range: assert property (@(posedge clk) disable iff (rst)
    battery_millivolts <= VOLT_MAX)
    else $error("stored voltage above limit");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    held_level <= LEVEL_RST)
    else $error("held level above full");
  a_source_code: assert property (@(posedge clk) disable iff (rst)
    $onehot(last_source))
    else $error("source code corrupt");
  a_bad_prop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.invalid_property) |-> (out_word.value == 15'd0))
    else $error("unsupported property with nonzero value");
`endif

endmodule

@@ rtl/battery_gauge_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge monitor
// Scales ADC words to millivolts and answers status, voltage, online and
// capacity queries.
// ----------------------------------------------------------------------------
// A query word passes the five front stages and then the result register before its result is valid.
// Throughput: one word per cycle through the five-stage scaling pipeline while the output is not stalled.
// Words complete in order; a sample updates the voltage before later queries.
// Reset (rst, synchronous): 8400 mV, held level 100, battery source,
// board scale 252 percent; pipeline and result register emptied.
module battery_gauge_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  bgm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bgm_pkg::out_word_t out_word
);
  import bgm_pkg::*;

  pend_t pend;
  logic  take;

  bgm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (take),
    .pend       (pend)
  );

  bgm_query u_query (
    .clk      (clk),
    .rst      (rst),
    .pend     (pend),
    .take     (take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
